[hdl/ukf_pkg.sv]
// ----------------------------------------------------------------------------
// ukf_pkg
// shared types, keyword table and character helpers for the url keyword filter
// ----------------------------------------------------------------------------
package ukf_pkg;

    localparam int unsigned MAX_URL_BYTES = 2047;
    localparam int unsigned WINDOW_CHARS  = 12;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned KEYWORD_COUNT = 25;
    localparam int unsigned WIN_W         = WINDOW_CHARS * 8;

    typedef logic [7:0]       t_char;
    typedef logic [WIN_W-1:0] t_window;

    // one classified byte handed from the front to the back
    typedef struct packed {
        t_char ch;      // folded character
        logic  word;    // folded character is [a-z0-9_]
        logic  accept;  // byte lies inside the length cap
        logic  last;    // final byte of the url
        logic  trunc;   // url has run past the cap so far
    } t_item;

    // patterns right-aligned: last character in the lowest byte, zero padding above
    localparam t_window KW_TEXT [KEYWORD_COUNT] = '{
        t_window'("rakuten"),   t_window'("jcb"),          t_window'("mizuho"),
        t_window'("mufg"),      t_window'("smbc"),         t_window'("japanpost"),
        t_window'("jp-bank"),   t_window'("yamato"),       t_window'("sagawa"),
        t_window'("kuroneko"),  t_window'("ana"),          t_window'("jal"),
        t_window'("aeon"),      t_window'("familymart"),   t_window'("family-mart"),
        t_window'("yodobashi"), t_window'("mercari"),      t_window'("paypay"),
        t_window'("docomo"),    t_window'("au"),           t_window'("softbank"),
        t_window'("jcom"),      t_window'("nicovideo"),    t_window'("amazon.co.jp"),
        t_window'("line.me")
    };

    localparam t_window APPLE_PAT = t_window'("apple.com");
    localparam t_window DOTJP_PAT = t_window'(".jp");
    localparam t_window JP_PAT    = t_window'("jp");

    // newest characters of the window spell the pattern
    function automatic logic ends_with(input t_window win, input t_window pat);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < WINDOW_CHARS; k++) begin
            if (pat[8*k +: 8] != 8'h00 && win[8*k +: 8] != pat[8*k +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic keyword_hit(input t_window win);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
            hit = hit | ends_with(win, KW_TEXT[i]);
        end
        return hit;
    endfunction

    function automatic logic is_word(input t_char c);
        return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || (c == "_");
    endfunction

endpackage

[hdl/ukf_front.sv]
// ----------------------------------------------------------------------------
// ukf_front
// byte intake: case folding, word class and length cap tracking
// ----------------------------------------------------------------------------
module ukf_front #(
    parameter int unsigned MAX_URL_BYTES = ukf_pkg::MAX_URL_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output ukf_pkg::t_item o_item
);

    localparam int unsigned CNT_W = $clog2(MAX_URL_BYTES + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_over_cap, n_over_cap;
    logic             w_accept;
    ukf_pkg::t_char   w_ch;

    assign w_accept = r_count < CNT_W'(MAX_URL_BYTES);

    // fold upper case only
    always_comb begin
        if (i_byte >= "A" && i_byte <= "Z") begin
            w_ch = i_byte + 8'h20;
        end else begin
            w_ch = i_byte;
        end
    end

    always_comb begin
        o_item.ch     = w_ch;
        o_item.word   = ukf_pkg::is_word(w_ch);
        o_item.accept = w_accept;
        o_item.last   = i_last;
        o_item.trunc  = r_over_cap | ~w_accept;
    end

    always_comb begin
        n_count    = r_count;
        n_over_cap = r_over_cap;
        if (i_push) begin
            if (i_last) begin
                n_count    = '0;
                n_over_cap = 1'b0;
            end else if (w_accept) begin
                n_count = r_count + 1'b1;
            end else begin
                n_over_cap = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_over_cap <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_over_cap <= n_over_cap;
        end
    end

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_URL_BYTES))
        else $error("byte count past cap");

endmodule

[hdl/ukf_queue.sv]
// ----------------------------------------------------------------------------
// ukf_queue
// short fifo of classified bytes between intake and matcher
// ----------------------------------------------------------------------------
module ukf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ukf_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ukf_pkg::t_item o_item
);

    localparam int unsigned DEPTH = ukf_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ukf_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_pop |=> o_full)
        else $error("queue lost an entry while full");

endmodule

[hdl/ukf_back.sv]
// ----------------------------------------------------------------------------
// ukf_back
// character window, pattern compare, sticky match state and result register
// ----------------------------------------------------------------------------
module ukf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ukf_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output logic           o_is_match,
    output logic           o_truncated
);

    ukf_pkg::t_window r_win, n_win, w_shift;
    logic r_hit, n_hit;
    logic r_dotjp, n_dotjp;
    logic r_apple, n_apple;
    logic r_apple_prev, n_apple_prev;
    logic r_out_valid, r_is_match, r_trunc;
    logic w_new_hit;

    // a last byte needs a free result slot, other bytes always go through
    assign o_pop = i_valid & (~i_item.last | ~r_out_valid | i_res_ready);

    assign w_shift = {r_win[ukf_pkg::WIN_W-9:0], i_item.ch};

    assign w_new_hit = (r_dotjp & ~i_item.word)
                     | ukf_pkg::keyword_hit(w_shift)
                     | (ukf_pkg::ends_with(w_shift, ukf_pkg::JP_PAT) & r_apple_prev);

    always_comb begin
        n_win        = r_win;
        n_hit        = r_hit;
        n_dotjp      = r_dotjp;
        n_apple      = r_apple;
        n_apple_prev = r_apple_prev;
        if (o_pop && i_item.accept) begin
            n_win        = w_shift;
            n_hit        = r_hit | w_new_hit;
            n_dotjp      = ukf_pkg::ends_with(w_shift, ukf_pkg::DOTJP_PAT);
            n_apple_prev = r_apple;
            n_apple      = r_apple | ukf_pkg::ends_with(w_shift, ukf_pkg::APPLE_PAT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_hit        <= 1'b0;
            r_dotjp      <= 1'b0;
            r_apple      <= 1'b0;
            r_apple_prev <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_win        <= '0;
            r_hit        <= 1'b0;
            r_dotjp      <= 1'b0;
            r_apple      <= 1'b0;
            r_apple_prev <= 1'b0;
        end else begin
            r_win        <= n_win;
            r_hit        <= n_hit;
            r_dotjp      <= n_dotjp;
            r_apple      <= n_apple;
            r_apple_prev <= n_apple_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_is_match <= n_hit | n_dotjp;
            r_trunc    <= i_item.trunc;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_is_match  = r_is_match;
    assign o_truncated = r_trunc;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |=> !r_hit && !r_dotjp && !r_apple && r_win == '0)
        else $error("url state not cleared after last byte");

    a_apple_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_apple_prev |-> r_apple)
        else $error("delayed apple flag set without current flag");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_res_ready |=> r_out_valid)
        else $error("pending result dropped");

endmodule

[hdl/url_keyword_filter_core.sv]
// ----------------------------------------------------------------------------
// url_keyword_filter_core
// streaming url filter for brand keywords, .jp boundaries and apple.com..jp
// ----------------------------------------------------------------------------
// A url enters as a run of byte transactions on the slave side, tlast marking
// its final byte. Each byte is folded to lower case and compared against a
// twelve character window of recent characters; the url matches if one of 25
// brand keywords appears, if ".jp" is followed by a non-word character or the
// end of the url, or if "jp" starts after the first "apple.com". Bytes past
// MAX_URL_BYTES are dropped and the cap acts as the end of the string. One
// result transaction leaves the master side per url, on its last byte.
// Throughput is one byte per clock, from the window compare in the matcher,
// while no last byte waits in the queue for a free result slot. With the queue
// empty an accepted last byte is written into the queue, the matcher then
// loads the result register from it, and the result is presented from that
// register. A two-entry queue separates intake from the matcher, and the
// result register lets intake go on while a result waits on m_axis_tready.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module url_keyword_filter_core #(
    parameter int unsigned MAX_URL_BYTES = ukf_pkg::MAX_URL_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // url bytes
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] url_byte
    input  logic       s_axis_tlast,   // last_byte
    // per-url result
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] is_match, [1] truncated, [7:2] zero
);

    ukf_pkg::t_item w_front_item, w_queue_item;
    logic w_push, w_full, w_queue_valid, w_pop;
    logic w_is_match, w_truncated;

    // a byte transaction completes whenever the queue has room
    assign s_axis_tready = ~w_full;
    assign w_push        = s_axis_tvalid & s_axis_tready;

    ukf_front #(
        .MAX_URL_BYTES (MAX_URL_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_item  (w_front_item)
    );

    ukf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    // matcher consumes one queued byte per clock unless a last byte waits for a free result slot
    ukf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_queue_valid),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_is_match  (w_is_match),
        .o_truncated (w_truncated)
    );

    assign m_axis_tdata = {6'b0, w_truncated, w_is_match};

endmodule
